// ----- design/sbpd_pkg.sv -----
package sbpd_pkg;

	localparam int MAX_PAYLOAD_BYTES = 9;
	localparam int BYTE_W = 8;
	localparam int ID_W = 5;
	localparam int BIT_CNT_W = 7;
	localparam int BYTE_CNT_W = 4;
	localparam int DATA_BITS = 7;

	localparam logic [2:0] TAG_START = 3'b100;
	localparam logic [2:0] TAG_CHANNEL = 3'b101;
	localparam logic [2:0] TAG_LENGTH = 3'b110;
	localparam logic [2:0] TAG_END = 3'b111;

	typedef logic [MAX_PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload_t;

	typedef enum logic [3:0] {
		EV_BYTE        = 4'd0,
		EV_EMPTY       = 4'd1,
		EV_LOST        = 4'd2,
		EV_BAD_IDLE    = 4'd3,
		EV_BAD_CHANNEL = 4'd4,
		EV_BAD_LENGTH  = 4'd5,
		EV_BAD_DATA    = 4'd6,
		EV_BAD_END     = 4'd7,
		EV_MISMATCH    = 4'd8,
		EV_TOO_LONG    = 4'd9
	} event_t;

	typedef struct packed {
		logic       load_start;
		logic       load_length;
		logic       absorb;
		logic       accept_end;
		logic       emit_event;
		logic       emit_byte;
		event_t     ev;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] tag;
		logic       data_bit7;
		logic       lost;
		logic       id_match;
		logic       len_too_long;
		logic       len_zero;
		logic       data_done;
		logic       count_zero;
		logic       count_one;
		logic       emit_last;
		logic       out_free;
	} dp_status_t;

endpackage

// ----- design/seven_bit_packet_deframer_top.sv -----
// The first result of a byte is registered and offered in the cycle after it is accepted.
// Header, data and error bytes are accepted back to back while the output register is free.
// An accepted end byte of a packet with more than one byte stalls the input while the
// remaining payload bytes leave through the single output register.
// Reset: arst_n asynchronously clears the frame state machine, the ids, the bit counters and
// the output valid; the payload store is cleared by each length byte instead.
module seven_bit_packet_deframer_top
	import sbpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        event_res,
	output logic [BYTE_W-1:0] payload_byte,
	output logic              last_of_run,
	output logic [ID_W-1:0]   seq_id
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	sbpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sbpd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.payload_byte (payload_byte),
		.last_of_run  (last_of_run),
		.seq_id       (seq_id)
	);

	// An item is never taken while a result still waits in the output register.
	a_no_accept_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall && out_valid && out_stall))
		else $error("item accepted while output register held a stalled result");

	// Every result other than a payload byte ends its run.
	a_event_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res != EV_BYTE)) |-> last_of_run)
		else $error("non-byte result not marked last");

	// A payload burst continues without a gap once a byte that is not last is taken.
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && (event_res == EV_BYTE) && !last_of_run)
		|=> (out_valid && (event_res == EV_BYTE)))
		else $error("payload burst interrupted");

	// No new item enters while a payload burst is still pending.
	a_burst_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_BYTE) && !last_of_run) |-> in_stall)
		else $error("input accepted during payload burst");

endmodule

// ----- design/sbpd_ctrl.sv -----
module sbpd_ctrl
	import sbpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_CHANNEL = 6'b000010,
		ST_LENGTH  = 6'b000100,
		ST_DATA    = 6'b001000,
		ST_END     = 6'b010000,
		ST_EMIT    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign in_stall = (state_q == ST_EMIT) || !status.out_free;
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.ev = EV_BYTE;
		state_next = state_q;
		case (state_q)
			ST_CHANNEL: begin
				if (accept) begin
					if (status.tag == TAG_CHANNEL) begin
						state_next = ST_LENGTH;
					end else begin
						state_next = ST_IDLE;
						cmd.emit_event = 1'b1;
						cmd.ev = EV_BAD_CHANNEL;
					end
				end
			end
			ST_LENGTH: begin
				if (accept) begin
					if (status.tag == TAG_LENGTH) begin
						cmd.load_length = 1'b1;
						if (status.len_too_long) begin
							state_next = ST_IDLE;
							cmd.emit_event = 1'b1;
							cmd.ev = EV_TOO_LONG;
						end else if (status.len_zero) begin
							state_next = ST_END;
						end else begin
							state_next = ST_DATA;
						end
					end else begin
						state_next = ST_IDLE;
						cmd.emit_event = 1'b1;
						cmd.ev = EV_BAD_LENGTH;
					end
				end
			end
			ST_DATA: begin
				if (accept) begin
					if (!status.data_bit7) begin
						cmd.absorb = 1'b1;
						if (status.data_done) begin
							state_next = ST_END;
						end
					end else begin
						state_next = ST_IDLE;
						cmd.emit_event = 1'b1;
						cmd.ev = EV_BAD_DATA;
					end
				end
			end
			ST_END: begin
				if (accept) begin
					state_next = ST_IDLE;
					if (status.tag != TAG_END) begin
						cmd.emit_event = 1'b1;
						cmd.ev = EV_BAD_END;
					end else if (!status.id_match) begin
						cmd.emit_event = 1'b1;
						cmd.ev = EV_MISMATCH;
					end else begin
						cmd.accept_end = 1'b1;
						if (status.count_zero) begin
							cmd.emit_event = 1'b1;
							cmd.ev = EV_EMPTY;
						end else begin
							cmd.emit_byte = 1'b1;
							if (!status.count_one) begin
								state_next = ST_EMIT;
							end
						end
					end
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_byte = 1'b1;
					if (status.emit_last) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				if (accept) begin
					if (status.tag == TAG_START) begin
						state_next = ST_CHANNEL;
						cmd.load_start = 1'b1;
						if (status.lost) begin
							cmd.emit_event = 1'b1;
							cmd.ev = EV_LOST;
						end
					end else begin
						state_next = ST_IDLE;
						cmd.emit_event = 1'b1;
						cmd.ev = EV_BAD_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ----- design/sbpd_datapath.sv -----
module sbpd_datapath
	import sbpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            event_res,
	output logic [BYTE_W-1:0]     payload_byte,
	output logic                  last_of_run,
	output logic [ID_W-1:0]       seq_id
);

	logic [ID_W-1:0]       current_id_q;
	logic [ID_W-1:0]       last_id_q;
	logic [BIT_CNT_W-1:0]  expected_q;
	logic [BIT_CNT_W-1:0]  received_q;
	logic [BYTE_CNT_W-1:0] idx_q;
	payload_t              payload_q;

	logic                  out_valid_q;
	event_t                event_q;
	logic [BYTE_W-1:0]     byte_q;
	logic                  last_q;
	logic [ID_W-1:0]       seq_id_q;

	logic [ID_W-1:0]       low;
	logic [BIT_CNT_W-1:0]  remaining;
	logic [2:0]            take;
	logic [DATA_BITS-1:0]  take_mask;
	payload_t              new_bits;
	logic [BYTE_CNT_W-1:0] count;
	logic [BYTE_CNT_W-1:0] sel_idx;
	logic                  load_out;

	assign low = rx_byte[ID_W-1:0];
	assign remaining = expected_q - received_q;
	assign take = (remaining <= BIT_CNT_W'(DATA_BITS)) ? remaining[2:0] : 3'(DATA_BITS);
	assign take_mask = DATA_BITS'((8'd1 << take) - 8'd1);
	assign new_bits = payload_t'($bits(payload_t)'(rx_byte[DATA_BITS-1:0] & take_mask)
		<< received_q);
	assign count = expected_q[BIT_CNT_W-1:3];
	assign sel_idx = cmd.accept_end ? '0 : idx_q;
	assign load_out = cmd.emit_event || cmd.emit_byte;

	assign status.tag = rx_byte[7:5];
	assign status.data_bit7 = rx_byte[7];
	assign status.lost = (low != (last_id_q + ID_W'(1)));
	assign status.id_match = (low == current_id_q);
	assign status.len_too_long = (low > ID_W'(MAX_PAYLOAD_BYTES));
	assign status.len_zero = (low == '0);
	assign status.data_done = (remaining <= BIT_CNT_W'(DATA_BITS));
	assign status.count_zero = (count == '0);
	assign status.count_one = (count == BYTE_CNT_W'(1));
	assign status.emit_last = (idx_q == count - BYTE_CNT_W'(1));
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_id_q <= '0;
			last_id_q <= '0;
			expected_q <= '0;
			received_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_start) begin
				current_id_q <= low;
				received_q <= '0;
			end
			if (cmd.load_length && !status.len_too_long) begin
				expected_q <= BIT_CNT_W'({low[BYTE_CNT_W-1:0], 3'b000});
			end
			if (cmd.absorb) begin
				received_q <= received_q + BIT_CNT_W'(take);
			end
			if (cmd.accept_end) begin
				last_id_q <= current_id_q;
			end
			if (cmd.emit_byte) begin
				idx_q <= sel_idx + BYTE_CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_length) begin
			payload_q <= '0;
		end else if (cmd.absorb) begin
			payload_q <= payload_q | new_bits;
		end
		if (load_out) begin
			seq_id_q <= cmd.load_start ? low : current_id_q;
			if (cmd.emit_byte) begin
				event_q <= EV_BYTE;
				byte_q <= payload_q[sel_idx];
				last_q <= (sel_idx == count - BYTE_CNT_W'(1));
			end else begin
				event_q <= cmd.ev;
				byte_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = 4'(event_q);
	assign payload_byte = byte_q;
	assign last_of_run = last_q;
	assign seq_id = seq_id_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
	import sbpd_pkg::*;
;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 60;
	localparam int FIRST_PHASE_BYTES = 200;
	localparam int SECOND_PHASE_BYTES = 370;

	localparam int BRK_NONE = 0;
	localparam int BRK_CHANNEL = 1;
	localparam int BRK_LENGTH = 2;
	localparam int BRK_DATA = 3;
	localparam int BRK_END_TAG = 4;
	localparam int BRK_END_ID = 5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CHANNEL,
		PH_LENGTH,
		PH_DATA,
		PH_END
	} frame_phase_t;

	typedef struct packed {
		event_t            ev;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [ID_W-1:0]   id;
	} frame_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [3:0]        event_res;
	logic [BYTE_W-1:0] payload_byte;
	logic              last_of_run;
	logic [ID_W-1:0]   seq_id;

	logic [BYTE_W-1:0] link_bytes [$];
	frame_result_t     result_queue [$];
	logic [BYTE_W-1:0] opening_bytes [$] = '{
		8'hFF,
		8'h81, 8'hA0, 8'hC1, 8'h7F, 8'h01, 8'hE1,
		8'h9F, 8'hBF, 8'hC0, 8'hFF,
		8'h80, 8'h00,
		8'h81, 8'hA5, 8'hE0,
		8'h82, 8'hBF, 8'hDF,
		8'h83, 8'hA0, 8'hC1, 8'h80,
		8'h84, 8'hA0, 8'hC0, 8'hE5,
		8'h85, 8'hA0, 8'hC0, 8'h00
	};

	frame_phase_t      fr_phase;
	logic [ID_W-1:0]   cur_id;
	logic [ID_W-1:0]   last_ok_id;
	int                want_bits;
	int                got_bits;
	logic [71:0]       frame_bits;

	logic [ID_W-1:0]   gen_last_id = '0;
	int                queued_total = 0;
	int                bytes_sent;
	int                burst_left;
	int                gap_left;
	int                hold_left;
	int                holds_done;
	logic [7:0]        pat_cycle;
	int                results_checked = 0;
	int                errors = 0;
	int                idle_cycles = 0;
	logic [9:0]        kinds_seen = '0;
	frame_result_t     want;

	seven_bit_packet_deframer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.payload_byte (payload_byte),
		.last_of_run  (last_of_run),
		.seq_id       (seq_id)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic post_result(input event_t ev, input logic [BYTE_W-1:0] data,
		input logic last);
		frame_result_t r;
		r.ev = ev;
		r.data = data;
		r.last = last;
		r.id = cur_id;
		result_queue = {result_queue, r};
	endtask

	task automatic predict_deframe(input logic [BYTE_W-1:0] b);
		logic [2:0]      tag;
		logic [ID_W-1:0] low;
		int              n_bytes;
		tag = b[7:5];
		low = b[4:0];
		case (fr_phase)
			PH_CHANNEL: begin
				if (tag == TAG_CHANNEL) begin
					fr_phase = PH_LENGTH;
				end else begin
					fr_phase = PH_IDLE;
					post_result(EV_BAD_CHANNEL, '0, 1'b1);
				end
			end
			PH_LENGTH: begin
				if (tag == TAG_LENGTH) begin
					frame_bits = '0;
					if (low > MAX_PAYLOAD_BYTES) begin
						fr_phase = PH_IDLE;
						post_result(EV_TOO_LONG, '0, 1'b1);
					end else begin
						want_bits = int'(low) * 8;
						fr_phase = (low == 0) ? PH_END : PH_DATA;
					end
				end else begin
					fr_phase = PH_IDLE;
					post_result(EV_BAD_LENGTH, '0, 1'b1);
				end
			end
			PH_DATA: begin
				if (!b[7]) begin
					for (int i = 0; i < DATA_BITS && got_bits < want_bits; i++) begin
						frame_bits[got_bits] = b[i];
						got_bits++;
					end
					if (got_bits >= want_bits)
						fr_phase = PH_END;
				end else begin
					fr_phase = PH_IDLE;
					post_result(EV_BAD_DATA, '0, 1'b1);
				end
			end
			PH_END: begin
				fr_phase = PH_IDLE;
				if (tag != TAG_END) begin
					post_result(EV_BAD_END, '0, 1'b1);
				end else if (low != cur_id) begin
					post_result(EV_MISMATCH, '0, 1'b1);
				end else begin
					last_ok_id = cur_id;
					n_bytes = want_bits / 8;
					if (n_bytes == 0) begin
						post_result(EV_EMPTY, '0, 1'b1);
					end else begin
						for (int k = 0; k < n_bytes; k++)
							post_result(EV_BYTE, frame_bits[k*8 +: 8], k == n_bytes - 1);
					end
				end
			end
			default: begin
				if (tag == TAG_START) begin
					cur_id = low;
					got_bits = 0;
					fr_phase = PH_CHANNEL;
					if (low != last_ok_id + 5'd1)
						post_result(EV_LOST, '0, 1'b1);
				end else begin
					fr_phase = PH_IDLE;
					post_result(EV_BAD_IDLE, '0, 1'b1);
				end
			end
		endcase
	endtask

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		link_bytes = {link_bytes, b};
		queued_total++;
	endtask

	function automatic logic [BYTE_W-1:0] byte_off_tag(input logic [2:0] tag);
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom);
		while (b[7:5] == tag)
			b = BYTE_W'($urandom);
		return b;
	endfunction

	// Mostly well-formed frames with random content; some are broken at one stage.
	task automatic queue_frame();
		logic [ID_W-1:0] id;
		int              sel;
		int              len;
		int              brk;
		int              n_data;
		int              bad_at;
		id = ($urandom_range(0, 4) != 0) ? gen_last_id + 5'd1 : ID_W'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 12)
			len = MAX_PAYLOAD_BYTES;
		else if (sel < 22)
			len = $urandom_range(MAX_PAYLOAD_BYTES + 1, 31);
		else
			len = $urandom_range(0, MAX_PAYLOAD_BYTES);
		brk = ($urandom_range(0, 99) < 78) ? BRK_NONE : $urandom_range(BRK_CHANNEL, BRK_END_ID);
		queue_byte({TAG_START, id});
		if (brk == BRK_CHANNEL) begin
			queue_byte(byte_off_tag(TAG_CHANNEL));
			return;
		end
		queue_byte({TAG_CHANNEL, ID_W'($urandom)});
		if (brk == BRK_LENGTH) begin
			queue_byte(byte_off_tag(TAG_LENGTH));
			return;
		end
		queue_byte({TAG_LENGTH, ID_W'(len)});
		if (len > MAX_PAYLOAD_BYTES)
			return;
		n_data = (len * 8 + DATA_BITS - 1) / DATA_BITS;
		bad_at = (n_data > 0) ? $urandom_range(0, n_data - 1) : -1;
		for (int i = 0; i < n_data; i++) begin
			if (brk == BRK_DATA && i == bad_at) begin
				queue_byte(8'h80 | BYTE_W'($urandom_range(0, 127)));
				return;
			end
			queue_byte({1'b0, 7'($urandom)});
		end
		if (brk == BRK_END_TAG || (brk == BRK_DATA && n_data == 0)) begin
			queue_byte(byte_off_tag(TAG_END));
		end else if (brk == BRK_END_ID) begin
			queue_byte({TAG_END, id ^ ID_W'($urandom_range(1, 31))});
		end else begin
			queue_byte({TAG_END, id});
			gen_last_id = id;
		end
	endtask

	task automatic queue_random_until(input int target);
		int n;
		while (queued_total < target) begin
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) queue_byte(BYTE_W'($urandom));
			end else begin
				queue_frame();
			end
		end
	endtask

	task automatic wait_drained();
		while (!(link_bytes.size() == 0 && !in_valid && result_queue.size() == 0))
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			bytes_sent <= 0;
			burst_left <= 1;
			gap_left <= 0;
			fr_phase = PH_IDLE;
			cur_id = '0;
			last_ok_id = '0;
			want_bits = 0;
			got_bits = 0;
			frame_bits = '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_deframe(rx_byte);
				bytes_sent <= bytes_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (link_bytes.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte <= link_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
			pat_cycle <= '0;
		end else begin
			pat_cycle <= pat_cycle + 8'd1;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if ((holds_done == 0 && bytes_sent >= 120) ||
				(holds_done == 1 && bytes_sent >= 300)) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end else begin
				case (pat_cycle[7:6])
					2'd0: out_stall <= 1'b0;
					2'd1: out_stall <= ($urandom_range(0, 3) == 0);
					2'd2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (pat_cycle[1:0] == 2'b11);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (event_res <= 4'd9)
				kinds_seen[event_res] = 1'b1;
			if (result_queue.size() == 0) begin
				if (errors < 10)
					$display("Unexpected result: event %0d byte %02h last %0b id %0d",
						event_res, payload_byte, last_of_run, seq_id);
				errors++;
			end else begin
				want = result_queue.pop_front();
				if (event_res !== want.ev || payload_byte !== want.data ||
					last_of_run !== want.last || seq_id !== want.id) begin
					if (errors < 10) begin
						$display("Mismatch: expected event %0d byte %02h last %0b id %0d",
							want.ev, want.data, want.last, want.id);
						$display("          got event %0d byte %02h last %0b id %0d",
							event_res, payload_byte, last_of_run, seq_id);
					end
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles, %0d results pending.",
				IDLE_LIMIT, result_queue.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (opening_bytes[i])
			queue_byte(opening_bytes[i]);
		wait_drained();
		queue_random_until(FIRST_PHASE_BYTES);
		wait_drained();
		queue_random_until(SECOND_PHASE_BYTES);
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d link bytes in framed, broken and noise sequences with bursty input.",
			bytes_sent);
		$display("Checked %0d results covering %0d of 10 event kinds; %0d mismatches.",
			results_checked, $countones(kinds_seen), errors);
		if (errors == 0 && result_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/sbpd_pkg.sv
design/sbpd_ctrl.sv
design/sbpd_datapath.sv
design/seven_bit_packet_deframer_top.sv
verif/tb_top.sv
